### design/tle_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the terminal line editor with echo.
// Used by every module of the block; depends on nothing.
package tle_pkg;

  // Default line store depth, and width of the fill count and line length
  localparam int LINE_DEPTH_DEF = 32;
  localparam int CNT_W          = 6;
  localparam int BYTE_W         = 8;
  localparam int ECHO_IDX_W     = 2;

  // Configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam logic REG_ECHO_ENABLE = 1'b0;  // word index of echo_enable

  // Character codes
  localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
  localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_ESC = 8'h1B;
  localparam logic [BYTE_W-1:0] CH_LBR = 8'h5B;  // '['
  localparam logic [BYTE_W-1:0] CH_K   = 8'h4B;  // 'K'

  // Last echo index for each kind of input byte
  localparam logic [ECHO_IDX_W-1:0] ECHO_LAST_CHAR  = 2'd0;
  localparam logic [ECHO_IDX_W-1:0] ECHO_LAST_CR    = 2'd1;
  localparam logic [ECHO_IDX_W-1:0] ECHO_LAST_ERASE = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ECHO,
    ST_LINE
  } tle_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // take the input item
    logic load_echo;  // load the next echo byte into the output register
    logic load_line;  // load the next line byte into the output register
  } tle_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             in_echo;    // incoming item produces echo bytes
    logic             in_line;    // incoming item completes a non-empty line
    logic             line_pend;  // current item has line bytes after its echo
    logic             echo_last;  // echo index sits on the final echo byte
    logic             line_last;  // read pointer sits on the final line byte
    logic             rd_ok;      // store read data matches the read pointer
    logic             out_free;   // output register can take a result
    logic [CNT_W-1:0] count;      // current fill count
  } tle_status_t;

  // Echo byte number idx for input byte c
  function automatic logic [BYTE_W-1:0] echo_char(input logic [BYTE_W-1:0] c,
                                                  input logic is_cr,
                                                  input logic is_erase,
                                                  input logic [ECHO_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] r;
    r = c;
    if (is_cr) begin
      r = (idx == 2'd0) ? CH_CR : CH_LF;
    end else if (is_erase) begin
      case (idx)
        2'd0:    r = CH_BS;
        2'd1:    r = CH_ESC;
        2'd2:    r = CH_LBR;
        default: r = CH_K;
      endcase
    end
    return r;
  endfunction

endpackage

### design/tle_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on tle_pkg for default sizes.
module tle_ram #(
  parameter int WIDTH = tle_pkg::BYTE_W,
  parameter int DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/tle_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: input acceptance, echo sequencing, line readout.
// Depends on tle_pkg for the state, command and status types.
module tle_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  tle_pkg::tle_status_t status,
  output tle_pkg::tle_cmd_t    cmd
);

  tle_pkg::tle_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tle_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.load_echo = 1'b0;
    cmd.load_line = 1'b0;
    unique case (state)
      tle_pkg::ST_IDLE: begin
        // no item is taken while reset is held
        s_tready   = !rst;
        cmd.accept = s_tvalid && !rst;
        if (s_tvalid && !rst) begin
          if (status.in_echo) begin
            state_next = tle_pkg::ST_ECHO;
          end else if (status.in_line) begin
            state_next = tle_pkg::ST_LINE;
          end
        end
      end
      tle_pkg::ST_ECHO: begin
        if (status.out_free) begin
          cmd.load_echo = 1'b1;
          if (status.echo_last) begin
            state_next = status.line_pend ? tle_pkg::ST_LINE : tle_pkg::ST_IDLE;
          end
        end
      end
      tle_pkg::ST_LINE: begin
        if (status.out_free && status.rd_ok) begin
          cmd.load_line = 1'b1;
          if (status.line_last) begin
            state_next = tle_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = tle_pkg::ST_IDLE;
    endcase
  end

endmodule

### design/tle_datapath.sv
`timescale 1ns / 1ps
// Datapath: fill count, line store RAM, echo and readout counters, output register.
// Depends on tle_pkg and tle_ram.
module tle_datapath #(
  parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         echo_enable,
  input  logic [tle_pkg::BYTE_W-1:0]   in_byte,
  input  tle_pkg::tle_cmd_t            cmd,
  output tle_pkg::tle_status_t         status,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_kind,
  output logic [tle_pkg::BYTE_W-1:0]   out_byte,
  output logic [tle_pkg::CNT_W-1:0]    out_len,
  output logic                         out_drop,
  output logic                         out_last
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam logic [tle_pkg::CNT_W-1:0] DEPTH_C = tle_pkg::CNT_W'(LINE_DEPTH);

  // Control state
  logic [tle_pkg::CNT_W-1:0]      count;
  logic                           line_pend;
  logic [tle_pkg::ECHO_IDX_W-1:0] echo_idx;
  logic [tle_pkg::CNT_W-1:0]      ptr;
  logic                           rd_ok;
  // Item payload
  logic [tle_pkg::BYTE_W-1:0]     c_reg;
  logic                           cr_reg;
  logic                           erase_reg;
  logic                           drop_reg;
  logic [tle_pkg::CNT_W-1:0]      line_len;
  logic [tle_pkg::ECHO_IDX_W-1:0] echo_lastidx;

  logic                           in_erase, in_cr, full, in_drop, in_append;
  logic                           wr_en, out_free;
  logic [tle_pkg::BYTE_W-1:0]     rd_data;

  // Classify the incoming byte against the current fill
  always_comb begin
    in_erase  = (in_byte == tle_pkg::CH_BS) || (in_byte == tle_pkg::CH_DEL);
    in_cr     = (in_byte == tle_pkg::CH_CR);
    full      = (count >= DEPTH_C);
    in_drop   = !in_erase && full;
    in_append = !in_erase && !full && !in_cr;
    wr_en     = cmd.accept && in_append;
    out_free  = !out_valid || out_ready;
  end

  // Status toward the controller
  always_comb begin
    status.in_echo   = echo_enable;
    status.in_line   = in_cr && !full && (count != '0);
    status.line_pend = line_pend;
    status.echo_last = (echo_idx == echo_lastidx);
    status.line_last = (ptr == line_len - tle_pkg::CNT_W'(1));
    status.rd_ok     = rd_ok;
    status.out_free  = out_free;
    status.count     = count;
  end

  // Fill count and per-item control
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      line_pend <= 1'b0;
      echo_idx  <= '0;
      ptr       <= '0;
      rd_ok     <= 1'b0;
    end else begin
      rd_ok <= !(cmd.accept || cmd.load_line);
      if (cmd.accept) begin
        echo_idx  <= '0;
        ptr       <= '0;
        line_pend <= in_cr && !full && (count != '0);
        if (in_erase) begin
          if (count != '0) begin
            count <= count - tle_pkg::CNT_W'(1);
          end
        end else if (!full) begin
          count <= in_cr ? '0 : count + tle_pkg::CNT_W'(1);
        end
      end else begin
        if (cmd.load_echo) begin
          echo_idx <= echo_idx + tle_pkg::ECHO_IDX_W'(1);
        end
        if (cmd.load_line) begin
          ptr <= ptr + tle_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Item payload captured on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      c_reg     <= in_byte;
      cr_reg    <= in_cr;
      erase_reg <= in_erase;
      drop_reg  <= in_drop;
      line_len  <= count;
      if (in_cr) begin
        echo_lastidx <= tle_pkg::ECHO_LAST_CR;
      end else if (in_erase) begin
        echo_lastidx <= tle_pkg::ECHO_LAST_ERASE;
      end else begin
        echo_lastidx <= tle_pkg::ECHO_LAST_CHAR;
      end
    end
  end

  // Line store
  tle_ram #(
    .WIDTH (tle_pkg::BYTE_W),
    .DEPTH (LINE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (in_byte),
    .rd_addr (ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_echo || cmd.load_line) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_echo) begin
      out_kind <= 1'b0;
      out_byte <= tle_pkg::echo_char(c_reg, cr_reg, erase_reg, echo_idx);
      out_len  <= '0;
      out_drop <= drop_reg;
      out_last <= (echo_idx == echo_lastidx) && !line_pend;
    end else if (cmd.load_line) begin
      out_kind <= 1'b1;
      out_byte <= rd_data;
      out_len  <= line_len;
      out_drop <= 1'b0;
      out_last <= (ptr == line_len - tle_pkg::CNT_W'(1));
    end
  end

endmodule

### design/terminal_line_editor_echo_top.sv
`timescale 1ns / 1ps
// Terminal line editor with echo: configuration port, controller and datapath.
// Depends on tle_pkg, tle_ctrl, tle_datapath (which holds tle_ram).
//
// Takes one received terminal byte at a time and edits a line of up to
// LINE_DEPTH bytes: BS or DEL erases the last byte, CR hands out the stored
// line as kind=1 items (each carrying the line length) and empties the
// store, other bytes are appended or dropped with the dropped flag when the
// store is full (a CR into a full store is dropped the same way). With
// echo_enable set, each byte first yields echo items (CR gives CR LF, an
// erase gives BS ESC [ K, others echo themselves). tlast marks the final
// item caused by an input byte. The block takes one byte while idle, then
// loads its echo items (0, 1, 2 or 4) one per cycle while the output register
// is free, then, for a completed line, the line bytes, each after the
// registered read port of the line RAM has caught up with the read pointer;
// an output stall holds the sequence. A new byte is accepted while the last
// result still waits in the output register. No clearing pass after reset.
module terminal_line_editor_echo_top #(
  parameter int LINE_DEPTH = tle_pkg::LINE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // Input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] rx_byte
  // Output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,   // [7:0] out_byte, [13:8] line_length,
                                                // [14] dropped, [15] zero
  output logic                       m_tuser,   // [0] kind
  output logic                       m_tlast,   // last
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tle_pkg::APB_AW-1:0] paddr,
  input  logic [tle_pkg::APB_DW-1:0] pwdata,
  output logic [tle_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  logic                          echo_enable;
  logic                          cfg_wr;
  tle_pkg::tle_cmd_t             cmd;
  tle_pkg::tle_status_t          status;
  logic [tle_pkg::BYTE_W-1:0]    out_byte;
  logic [tle_pkg::CNT_W-1:0]     out_len;
  logic                          out_drop;

  // Register write and read
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_enable <= 1'b1;
    end else if (cfg_wr && (paddr[2] == tle_pkg::REG_ECHO_ENABLE)) begin
      echo_enable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == tle_pkg::REG_ECHO_ENABLE) begin
      prdata[0] = echo_enable;
    end
  end

  // Controller
  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath
  tle_datapath #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .echo_enable (echo_enable),
    .in_byte     (s_tdata),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_kind    (m_tuser),
    .out_byte    (out_byte),
    .out_len     (out_len),
    .out_drop    (out_drop),
    .out_last    (m_tlast)
  );

  assign m_tdata = {1'b0, out_drop, out_len, out_byte};

  // Fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= tle_pkg::CNT_W'(LINE_DEPTH))
    else $error("line count beyond store depth");

  // No result is loaded while the block takes input
  a_no_load_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(cmd.load_echo || cmd.load_line))
    else $error("result loaded while idle");

  // Line items never carry the drop flag
  a_line_nodrop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> !m_tdata[14])
    else $error("drop flag on a line item");

  // Echo items carry zero line length
  a_echo_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[13:8] == '0))
    else $error("nonzero length on an echo item");

endmodule
